/* hw/rtl/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define AST_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("lbl");
`define AST_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("lbl");
`endif

/* hw/rtl/rau_pkg.sv */
package rau_pkg;
	localparam int OperandWidth = 32;
	localparam int ProdWidth = 64;
	localparam int CntWidth = 7;

	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_MUL = 2'd2,
		FUNC_DIV = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SUM,
		ST_GCD_CHK,
		ST_REM_INIT,
		ST_REM_STEP,
		ST_GCD_SWAP,
		ST_QN_INIT,
		ST_QN_STEP,
		ST_QD_INIT,
		ST_QD_STEP,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		DIV_GCD = 2'd0,
		DIV_NUM = 2'd1,
		DIV_DEN = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic sum;
		logic gcd_init;
		logic div_init;
		logic div_step;
		logic gcd_swap;
		div_sel_t div_sel;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic err;
		logic y_zero;
		logic div_last;
	} sts_t;
endpackage

/* hw/rtl/rau_datapath.sv */
module rau_datapath #(
	parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
	input  logic                     clk,
	input  logic [1:0]               func,
	input  logic [OPERAND_WIDTH-1:0] a_num,
	input  logic [OPERAND_WIDTH-1:0] a_den,
	input  logic [OPERAND_WIDTH-1:0] b_num,
	input  logic [OPERAND_WIDTH-1:0] b_den,
	input  rau_pkg::cmd_t            cmd,
	output rau_pkg::sts_t            sts,
	output logic [63:0]              res_num,
	output logic [62:0]              res_den,
	output logic                     err
);
	import rau_pkg::*;
	localparam int MW = OPERAND_WIDTH;
	localparam int PW = 2 * OPERAND_WIDTH;

	logic [1:0] func_q;
	logic [MW-1:0] an_q, ad_q, bn_q, bd_q;
	logic sn_an, sn_ad, sn_bn, sn_bd;
	logic [PW-1:0] p1_q, p2_q, num_q, den_q, x_q, y_q;
	logic p1n_q, p2n_q, numn_q, denn_q, err_q;
	logic [PW-1:0] rem_q, quo_q, dvd_q, dvs_q;
	logic [CntWidth-1:0] cnt_q;
	logic [MW-1:0] m_a, m_b;
	logic [PW-1:0] prod;
	logic [PW:0] trial;
	logic [PW:0] rsh;
	logic [63:0] quo_w;
	logic [63:0] rn;
	logic [PW-1:0] dvd_sel;

	function automatic logic [MW-1:0] absv(input logic [MW-1:0] v);
		return v[MW-1] ? (~v + 1'b1) : v;
	endfunction

	assign sn_an = an_q[MW-1];
	assign sn_ad = ad_q[MW-1];
	assign sn_bn = bn_q[MW-1];
	assign sn_bd = bd_q[MW-1];

	always_comb begin
		m_a = absv(an_q);
		m_b = absv(bd_q);
		if (cmd.mul1 && func_q == FUNC_MUL) begin
			m_b = absv(bn_q);
		end
		if (cmd.mul2) begin
			unique case (func_q)
				FUNC_ADD, FUNC_SUB: begin
					m_a = absv(bn_q);
					m_b = absv(ad_q);
				end
				FUNC_MUL: begin
					m_a = absv(ad_q);
					m_b = absv(bd_q);
				end
				default: begin
					m_a = absv(ad_q);
					m_b = absv(bn_q);
				end
			endcase
		end
		if (cmd.sum) begin
			m_a = absv(ad_q);
			m_b = absv(bd_q);
		end
	end
	assign prod = PW'(m_a) * PW'(m_b);

	always_comb begin
		unique case (cmd.div_sel)
			DIV_GCD: dvd_sel = x_q;
			DIV_NUM: dvd_sel = num_q;
			default: dvd_sel = den_q;
		endcase
	end
	assign rsh = {rem_q, dvd_q[PW-1]};
	assign trial = rsh - {1'b0, dvs_q};
	assign quo_w = 64'(quo_q);
	assign rn = (numn_q ^ denn_q && num_q != '0) ? ~quo_w + 1'b1 : quo_w;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			an_q <= a_num;
			ad_q <= a_den;
			bn_q <= b_num;
			bd_q <= b_den;
			err_q <= (a_den == '0) || (b_den == '0) || (func == FUNC_DIV && b_num == '0);
		end
		if (cmd.mul1) begin
			p1_q <= prod;
			p1n_q <= ((func_q == FUNC_MUL) ? (sn_an ^ sn_bn) : (sn_an ^ sn_bd))
				&& prod != '0;
		end
		if (cmd.mul2) begin
			p2_q <= prod;
			unique case (func_q)
				FUNC_ADD: p2n_q <= (sn_bn ^ sn_ad) && prod != '0;
				FUNC_SUB: p2n_q <= !(sn_bn ^ sn_ad) && prod != '0;
				FUNC_MUL: p2n_q <= (sn_ad ^ sn_bd) && prod != '0;
				default: p2n_q <= (sn_ad ^ sn_bn) && prod != '0;
			endcase
		end
		if (cmd.sum) begin
			if (func_q == FUNC_MUL || func_q == FUNC_DIV) begin
				num_q <= p1_q;
				numn_q <= p1n_q;
				den_q <= p2_q;
				denn_q <= p2n_q;
			end else begin
				if (p1n_q == p2n_q) begin
					num_q <= p1_q + p2_q;
					numn_q <= p1n_q;
				end else if (p1_q >= p2_q) begin
					num_q <= p1_q - p2_q;
					numn_q <= p1n_q && p1_q != p2_q;
				end else begin
					num_q <= p2_q - p1_q;
					numn_q <= p2n_q;
				end
				den_q <= prod;
				denn_q <= sn_ad ^ sn_bd;
			end
		end
		if (cmd.gcd_init) begin
			x_q <= num_q;
			y_q <= den_q;
		end
		if (cmd.div_init) begin
			dvd_q <= dvd_sel;
			dvs_q <= (cmd.div_sel == DIV_GCD) ? y_q : x_q;
			rem_q <= '0;
			quo_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			cnt_q <= cnt_q + 1'b1;
			if (!trial[PW]) begin
				rem_q <= trial[PW-1:0];
				quo_q <= {quo_q[PW-2:0], 1'b1};
			end else begin
				rem_q <= rsh[PW-1:0];
				quo_q <= {quo_q[PW-2:0], 1'b0};
			end
		end
		if (cmd.gcd_swap) begin
			x_q <= y_q;
			y_q <= rem_q;
		end
		if (cmd.div_init && cmd.div_sel == DIV_DEN) begin
			res_num <= rn;
		end else if (cmd.fin && err_q) begin
			res_num <= '0;
		end
		if (cmd.fin) begin
			res_den <= err_q ? '0 : 63'(quo_q);
			err <= err_q;
		end
	end

	assign sts.err = err_q;
	assign sts.y_zero = (y_q == '0);
	assign sts.div_last = (cnt_q == CntWidth'(PW - 1));
endmodule

/* hw/rtl/rau_ctrl.sv */
module rau_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_fire,
	input  logic          out_fire,
	input  rau_pkg::sts_t sts,
	output rau_pkg::cmd_t cmd,
	output logic          busy,
	output logic          out_valid
);
	import rau_pkg::*;
	state_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (in_fire) st_d = ST_MUL1;
			ST_MUL1: st_d = ST_MUL2;
			ST_MUL2: st_d = ST_SUM;
			ST_SUM: st_d = sts.err ? ST_QD_STEP : ST_GCD_CHK;
			ST_GCD_CHK: st_d = ST_REM_INIT;
			ST_REM_INIT: st_d = sts.y_zero ? ST_QN_INIT : ST_REM_STEP;
			ST_REM_STEP: if (sts.div_last) st_d = ST_GCD_SWAP;
			ST_GCD_SWAP: st_d = ST_REM_INIT;
			ST_QN_INIT: st_d = ST_QN_STEP;
			ST_QN_STEP: if (sts.div_last) st_d = ST_QD_INIT;
			ST_QD_INIT: st_d = ST_QD_STEP;
			ST_QD_STEP: if (sts.div_last || sts.err) st_d = ST_FIN;
			ST_FIN: st_d = ST_OUT;
			ST_OUT: if (out_fire) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (st_q)
			ST_IDLE: cmd.load = in_fire;
			ST_MUL1: cmd.mul1 = 1'b1;
			ST_MUL2: cmd.mul2 = 1'b1;
			ST_SUM: cmd.sum = 1'b1;
			ST_GCD_CHK: cmd.gcd_init = 1'b1;
			ST_REM_INIT: cmd.div_init = !sts.y_zero;
			ST_REM_STEP: cmd.div_step = 1'b1;
			ST_GCD_SWAP: cmd.gcd_swap = 1'b1;
			ST_QN_INIT: begin
				cmd.div_init = 1'b1;
				cmd.div_sel = DIV_NUM;
			end
			ST_QN_STEP: begin
				cmd.div_step = 1'b1;
				cmd.div_sel = DIV_NUM;
			end
			ST_QD_INIT: begin
				cmd.div_init = 1'b1;
				cmd.div_sel = DIV_DEN;
			end
			ST_QD_STEP: begin
				cmd.div_step = !sts.err;
				cmd.div_sel = DIV_DEN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				cmd.div_sel = DIV_DEN;
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (st_q != ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
endmodule

/* hw/rtl/rational_arithmetic_unit.sv */
// channel | dir | tdata bits                                   | tuser
// s_axis  | in  | func, a_num, a_den, b_num, b_den (130 -> 136) | -
// m_axis  | out | res_num, res_den (127 -> 128)                 | err
// The 64-step restoring divider serves both the gcd remainder steps and the reduction.
// An item that raises err skips the gcd and the divisions and goes from the sum to the result.
// Reset clears the controller only; one item is in flight at a time.
// A stalled result holds until m_axis_tready; s_axis_tready is low meanwhile.
module rational_arithmetic_unit #(
	parameter int OPERAND_WIDTH = rau_pkg::OperandWidth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // func, a_num, a_den, b_num, b_den
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // res_num, res_den
	output logic         m_axis_tuser   // err
);
	import rau_pkg::*;
	cmd_t cmd;
	sts_t sts;
	logic busy;
	logic [63:0] res_num;
	logic [62:0] res_den;
	logic [63:0] dp_num;
	logic [62:0] dp_den;
	logic dp_err;

	assign s_axis_tready = !busy;

	rau_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_fire(s_axis_tvalid && s_axis_tready),
		.out_fire(m_axis_tvalid && m_axis_tready),
		.sts(sts), .cmd(cmd), .busy(busy), .out_valid(m_axis_tvalid)
	);

	rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
		.clk(clk),
		.func(s_axis_tdata[1:0]),
		.a_num(s_axis_tdata[2 +: OPERAND_WIDTH]),
		.a_den(s_axis_tdata[34 +: OPERAND_WIDTH]),
		.b_num(s_axis_tdata[66 +: OPERAND_WIDTH]),
		.b_den(s_axis_tdata[98 +: OPERAND_WIDTH]),
		.cmd(cmd), .sts(sts),
		.res_num(dp_num), .res_den(dp_den), .err(dp_err)
	);

	assign res_num = dp_num;
	assign res_den = dp_den;
	assign m_axis_tdata = {1'b0, res_den, res_num};
	assign m_axis_tuser = dp_err;
endmodule

/* hw/rtl/rau_checker.sv */
module rau_sva (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [127:0] m_axis_tdata,
	input logic m_axis_tuser
);
`include "assert_macros.svh"
	`AST_IMP(a_excl, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`AST_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`AST_IMP(a_errz, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata[126:64] == '0)
	`AST_IMP(a_den, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[126:64] != '0)
endmodule

bind rational_arithmetic_unit rau_sva u_chk (.*);

/* tb/sv/rau_checker.sv */
`timescale 1ns / 1ps
module rau_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [127:0] m_axis_tdata,
	input  logic         m_axis_tuser,
	output int           fail_count,
	output int           pending,
	output int           results_seen
);
	import rau_pkg::*;

	typedef struct {
		logic [63:0] num;
		logic [62:0] den;
		logic        err;
	} quotient_t;

	quotient_t reduced_q[$];

	function automatic logic [63:0] mag_of(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
		logic [63:0] t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic quotient_t reduce_fraction(logic [135:0] d);
		func_t op;
		logic signed [63:0] an, ad, bn, bd, p, q, dn, dd;
		logic [63:0] pm, qm, nm, dm, g;
		logic pn, qn, nn, dneg, neg;
		quotient_t r;
		op = func_t'(d[1:0]);
		an = $signed(d[33:2]);
		ad = $signed(d[65:34]);
		bn = $signed(d[97:66]);
		bd = $signed(d[129:98]);
		r.err = 0;
		if (ad == 0 || bd == 0 || (op == FUNC_DIV && bn == 0)) begin
			r.num = 0;
			r.den = 0;
			r.err = 1;
			return r;
		end
		case (op)
			FUNC_ADD, FUNC_SUB: begin
				p = an; q = bd; dn = (op == FUNC_SUB) ? -bn : bn; dd = ad;
				pm = mag_of(p) * mag_of(q);
				pn = ((p < 0) != (q < 0)) && pm != 0;
				qm = mag_of(dn) * mag_of(dd);
				qn = ((dn < 0) != (dd < 0)) && qm != 0;
				if (pn == qn) begin
					nm = pm + qm; nn = pn;
				end else if (pm >= qm) begin
					nm = pm - qm; nn = pn;
				end else begin
					nm = qm - pm; nn = qn;
				end
				if (nm == 0) nn = 0;
				dm = mag_of(ad) * mag_of(bd);
				dneg = (ad < 0) != (bd < 0);
			end
			FUNC_MUL: begin
				nm = mag_of(an) * mag_of(bn);
				nn = ((an < 0) != (bn < 0)) && nm != 0;
				dm = mag_of(ad) * mag_of(bd);
				dneg = (ad < 0) != (bd < 0);
			end
			default: begin
				nm = mag_of(an) * mag_of(bd);
				nn = ((an < 0) != (bd < 0)) && nm != 0;
				dm = mag_of(ad) * mag_of(bn);
				dneg = (ad < 0) != (bn < 0);
			end
		endcase
		g = euclid(nm, dm);
		nm = nm / g;
		dm = dm / g;
		neg = (nn != dneg) && nm != 0;
		r.num = neg ? -nm : nm;
		r.den = dm[62:0];
		return r;
	endfunction

	assign pending = reduced_q.size();

	always @(posedge clk or negedge arst_n) begin
		quotient_t e;
		if (!arst_n) begin
			fail_count <= 0;
			results_seen <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				reduced_q.push_back(reduce_fraction(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen <= results_seen + 1;
				if (reduced_q.size() == 0) begin
					$display("%0t: unexpected beat %h err %b", $time, m_axis_tdata,
						m_axis_tuser);
					fail_count <= fail_count + 1;
				end else begin
					e = reduced_q.pop_front();
					if (m_axis_tdata[63:0] !== e.num || m_axis_tdata[126:64] !== e.den
						|| m_axis_tdata[127] !== 1'b0 || m_axis_tuser !== e.err) begin
						$display("%0t: expected num %0d den %0d err %b, got num %0d den %0d err %b",
							$time, $signed(e.num), e.den, e.err, $signed(m_axis_tdata[63:0]),
							m_axis_tdata[126:64], m_axis_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
	import rau_pkg::*;

	localparam int RandomItems = 600;
	localparam int HoldCycles = 700;
	localparam longint CycleLimit = 30000000;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [127:0] m_axis_tdata;
	logic         m_axis_tuser;
	int           fail_count, pending, results_seen;
	bit           calm = 0;
	bit           hold_off = 0;
	int           hold_cnt = 0;
	int           idle_left = 0;
	longint       cycles = 0;

	always #1 clk = ~clk;

	rational_arithmetic_unit dut (.*);

	rau_checker chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("timeout");
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else if (hold_off && hold_cnt < HoldCycles) begin
			m_axis_tready <= 0;
			hold_cnt <= hold_cnt + 1;
		end else if (idle_left > 0) begin
			m_axis_tready <= 0;
			idle_left <= idle_left - 1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 0;
			idle_left <= int'($urandom_range(0, 6));
		end else begin
			m_axis_tready <= 1;
		end
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0001;
			3: return 0;
			4, 5: return $signed($urandom_range(0, 40)) - 20;
			6: return $urandom_range(0, 65535) * ($urandom_range(0, 1) ? 1 : -1);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(func_t op, logic [31:0] an, logic [31:0] ad,
		logic [31:0] bn, logic [31:0] bd);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {6'b0, bd, bn, ad, an, op};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_random();
		logic [31:0] ad, bd;
		ad = pick_operand();
		bd = pick_operand();
		if ($urandom_range(0, 9) != 0) begin
			if (ad == 0) ad = 1;
			if (bd == 0) bd = 3;
		end
		send_item(func_t'($urandom_range(0, 3)), pick_operand(), ad, pick_operand(), bd);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		func_t op;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		for (int k = 0; k < 4; k++) begin
			op = func_t'(k);
			send_item(op, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001, 32'h8000_0001);
			send_item(op, 32'h8000_0000, 1, 32'h8000_0000, 32'h8000_0000);
			send_item(op, 6, -4, 9, 15);
			send_item(op, 0, 5, 0, -7);
			send_item(op, 3, 0, 1, 2);
		end
		send_item(FUNC_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
		send_item(FUNC_ADD, 1, 2, -1, 2);
		send_item(FUNC_DIV, 5, 1, 3, 0);
		drain();
		hold_off <= 1;
		s_axis_tvalid <= 1;
		s_axis_tdata <= {6'b0, 32'd7, 32'd5, 32'd3, 32'd2, FUNC_ADD};
		do @(posedge clk); while (!s_axis_tready);
		s_axis_tdata <= {6'b0, 32'd6, 32'd9, 32'hffff_fffc, 32'd11, FUNC_SUB};
		while (hold_cnt < HoldCycles) @(posedge clk);
		hold_off <= 0;
		do @(posedge clk); while (!s_axis_tready);
		drain();
		for (int i = 0; i < RandomItems; i++) begin
			if (i == RandomItems / 2) drain();
			if (i == RandomItems - 60) calm = 1;
			send_random();
		end
		drain();
		repeat (200) @(posedge clk);
		$display("%0d results checked: all four operations, zero and extreme operands,",
			results_seen);
		$display("error cases, output stalls and input gaps");
		if (fail_count == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
